[hdl/bsd_pkg.sv]
// Package for the bounded stack with dump block.
// Holds the shared widths, defaults, operation and result codes, and the command type.
// Depends on nothing.
package bsd_pkg;

  localparam int DATA_W      = 32;
  localparam int CAP_W       = 7;
  localparam int DEPTH_DEF   = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP       = 2'd1,
    OP_DUMP_DOWN = 2'd2,
    OP_DUMP_UP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage

[hdl/bsd_front.sv]
// Front end of the stack block: accepts transactions and decodes them into commands.
// Depends on bsd_pkg; feeds bsd_queue.
module bsd_front
  import bsd_pkg::*;
(
  input  logic                      start,
  input  logic [1:0]                in_opcode,
  input  logic signed [DATA_W-1:0]  in_push_value,
  input  logic                      q_full,
  output logic                      busy,
  output logic                      q_push,
  output cmd_t                      q_cmd
);

  op_t op_dec;

  always_comb begin
    unique case (in_opcode)
      2'd0: op_dec = OP_PUSH;
      2'd1: op_dec = OP_POP;
      2'd2: op_dec = OP_DUMP_DOWN;
      2'd3: op_dec = OP_DUMP_UP;
      default: op_dec = OP_PUSH;
    endcase
  end

  assign busy        = q_full;
  assign q_push      = start && !q_full;
  assign q_cmd.op    = op_dec;
  assign q_cmd.value = in_push_value;

endmodule

[hdl/bsd_queue.sv]
// Short command queue between the front end and the back end of the stack block.
// Depends on bsd_pkg for the command type and the queue depth.
module bsd_queue
  import bsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  cmd_t  push_cmd,
  input  logic  pop,
  output logic  full,
  output logic  vld,
  output cmd_t  head
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == QCW'(QUEUE_DEPTH));
  assign vld     = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hdl/bsd_back.sv]
// Back end of the stack block: executes commands against the store and fill count.
// Depends on bsd_pkg; takes commands from bsd_queue and drives the result ports.
module bsd_back
  import bsd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CAP_W-1:0]          capacity,
  input  logic                      q_vld,
  input  cmd_t                      q_cmd,
  output logic                      q_pop,
  output logic                      out_strobe,
  output logic [1:0]                out_kind,
  output logic signed [DATA_W-1:0]  out_entry,
  output logic                      out_last
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (FW > CAP_W) ? FW : CAP_W;

  logic signed [DATA_W-1:0]  mem [DEPTH];
  logic signed [DATA_W-1:0]  rd_data_r;

  state_t          st_r, st_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic            up_r, up_nxt;
  logic            res_vld_r, res_vld_nxt;
  kind_t           res_kind_r, res_kind_nxt;
  logic            res_last_r, res_last_nxt;
  logic            res_dump_r, res_dump_nxt;

  logic            mem_we;
  logic [AW-1:0]   wr_addr, rd_addr, dump_addr;
  logic            full, empty, dump_last;
  logic [FW-1:0]   top_idx;

  assign top_idx   = fill_r - FW'(1);
  assign full      = (CW'(fill_r) >= CW'(capacity)) || (fill_r >= FW'(DEPTH));
  assign empty     = (fill_r == '0);
  assign dump_last = (FW'(cnt_r) == top_idx);
  assign dump_addr = up_r ? cnt_r : AW'(top_idx - FW'(cnt_r));
  assign wr_addr   = fill_r[AW-1:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_vld && !empty && (q_cmd.op == OP_DUMP_DOWN || q_cmd.op == OP_DUMP_UP)) begin
          st_nxt = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (dump_last) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    rd_addr      = dump_addr;
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    up_nxt       = up_r;
    res_vld_nxt  = 1'b0;
    res_kind_nxt = KIND_ENTRY;
    res_last_nxt = 1'b0;
    res_dump_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_vld) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            OP_PUSH: begin
              if (full) begin
                res_vld_nxt  = 1'b1;
                res_kind_nxt = KIND_FULL;
                res_last_nxt = 1'b1;
              end else begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + FW'(1);
              end
            end
            OP_POP: begin
              if (empty) begin
                res_vld_nxt  = 1'b1;
                res_kind_nxt = KIND_EMPTY;
                res_last_nxt = 1'b1;
              end else begin
                fill_nxt = top_idx;
              end
            end
            OP_DUMP_DOWN, OP_DUMP_UP: begin
              if (empty) begin
                res_vld_nxt  = 1'b1;
                res_kind_nxt = KIND_EMPTY;
                res_last_nxt = 1'b1;
              end else begin
                cnt_nxt = '0;
                up_nxt  = (q_cmd.op == OP_DUMP_UP);
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_DUMP: begin
        res_vld_nxt  = 1'b1;
        res_kind_nxt = KIND_ENTRY;
        res_last_nxt = dump_last;
        res_dump_nxt = 1'b1;
        cnt_nxt      = cnt_r + AW'(1);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      fill_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      fill_r    <= fill_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    up_r       <= up_nxt;
    res_kind_r <= res_kind_nxt;
    res_last_r <= res_last_nxt;
    res_dump_r <= res_dump_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_cmd.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_strobe = res_vld_r;
  assign out_kind   = res_kind_r;
  assign out_entry  = res_dump_r ? rd_data_r : '0;
  assign out_last   = res_last_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill count exceeds store depth");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DUMP) |-> (fill_r != '0))
    else $error("dump running on an empty stack");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_cmd.op == OP_PUSH && !full) |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("accepted push did not grow the stack");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_kind_r != KIND_ENTRY) |-> (res_last_r && !res_dump_r))
    else $error("error result not marked last");

  a_no_pop_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DUMP) |-> !q_pop)
    else $error("command taken while a dump is running");
`endif

endmodule

[hdl/bounded_stack_with_dump_top.sv]
// Top level of the bounded stack with dump block.
// Depends on bsd_pkg, bsd_front, bsd_queue and bsd_back; holds the capacity register.
//
//   Channel   Handshake                     Payload
//   input     start, busy (taken: start & !busy)  in_opcode, in_push_value
//   result    out_strobe, one cycle per result  out_kind, out_entry, out_last
//   config    cfg_we                        cfg_wdata (capacity)
//
// A push or pop runs as it leaves the queue: one transaction per cycle is sustained while
// no dump runs. A dump stays in the dump state until its last entry is read, one entry per
// cycle out of the single read port of the store; entries and result flags are registered
// on the way out. Busy rises when the two-entry command queue is full.
// Reset clears the fill count, queue and control; the store is not cleared.
// The receiver cannot stall, so results are never held back.
module bounded_stack_with_dump_top
  import bsd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic signed [DATA_W-1:0]  in_push_value,
  output logic                      out_strobe,
  output logic [1:0]                out_kind,
  output logic signed [DATA_W-1:0]  out_entry,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_wdata
);

  logic [CAP_W-1:0] cap_r;
  logic             q_full, q_push, q_vld, q_pop;
  cmd_t             q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  bsd_front u_front (
    .start         (start),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .q_full        (q_full),
    .busy          (busy),
    .q_push        (q_push),
    .q_cmd         (q_in)
  );

  bsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .vld      (q_vld),
    .head     (q_head)
  );

  bsd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (cap_r),
    .q_vld      (q_vld),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_kind   (out_kind),
    .out_entry  (out_entry),
    .out_last   (out_last)
  );

endmodule

[bench/tb_bounded_stack_with_dump_top.sv]
`timescale 1ns / 100ps
// Testbench for bounded_stack_with_dump_top: a directed table, then random push, pop and dump
// traffic under several capacities, checked against the table or a stack model in this file.
// Depends on bsd_pkg and the bounded_stack_with_dump_top RTL.
module tb_bounded_stack_with_dump_top;
  import bsd_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] entry;
    logic              last;
  } stack_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CAP_W-1:0]  cap;
    op_t               op;
    logic [DATA_W-1:0] value;
    logic              typed;
    kind_t             x_kind;
    logic [DATA_W-1:0] x_entry;
  } stim_row_t;

  localparam int NUM_ROWS      = 27;
  localparam int NUM_SEGMENTS  = 6;
  localparam int SETTLE_CYCLES = 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_opcode = OP_PUSH;
  logic [DATA_W-1:0] in_push_value = '0;
  logic              out_strobe;
  logic [1:0]        out_kind;
  logic [DATA_W-1:0] out_entry;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;

  logic [DATA_W-1:0] model_mem [DEPTH_DEF];
  int unsigned       model_fill;
  logic [CAP_W-1:0]  model_cap;
  stack_result_t     pending_results [$];

  bit                expect_typed = 1'b0;
  kind_t             typed_kind = KIND_ENTRY;
  logic [DATA_W-1:0] typed_entry = '0;
  int                sender_idle_pct = 0;
  int                error_count = 0;

  int seg_cap      [NUM_SEGMENTS] = '{64, 3, 127, 0, 9, 40};
  int seg_items    [NUM_SEGMENTS] = '{100, 50, 80, 40, 50, 50};
  int seg_push_pct [NUM_SEGMENTS] = '{95, 50, 85, 40, 55, 70};
  int seg_dump_pct [NUM_SEGMENTS] = '{4, 15, 8, 10, 15, 10};

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, 7'd0,   OP_POP,       32'h0000_0000, 1'b1, KIND_EMPTY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_DUMP_DOWN, 32'h0000_0000, 1'b1, KIND_EMPTY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_DUMP_UP,   32'hffff_ffff, 1'b1, KIND_EMPTY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'h8000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_DUMP_UP,   32'h0000_0000, 1'b1, KIND_ENTRY, 32'h8000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'h7fff_ffff, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'hffff_ffff, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_DUMP_DOWN, 32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_DUMP_UP,   32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b1, 7'd2,   OP_PUSH,      32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'h0000_0005, 1'b1, KIND_FULL,  32'h0000_0000},
    '{1'b0, 7'd0,   OP_POP,       32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_DUMP_DOWN, 32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_POP,       32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_POP,       32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'h1234_5678, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'h5555_5555, 1'b1, KIND_FULL,  32'h0000_0000},
    '{1'b1, 7'd0,   OP_PUSH,      32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'haaaa_aaaa, 1'b1, KIND_FULL,  32'h0000_0000},
    '{1'b0, 7'd0,   OP_POP,       32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_POP,       32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_POP,       32'h0000_0000, 1'b1, KIND_EMPTY, 32'h0000_0000},
    '{1'b1, 7'd127, OP_PUSH,      32'h0000_0000, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_PUSH,      32'haaaa_aaaa, 1'b0, KIND_ENTRY, 32'h0000_0000},
    '{1'b0, 7'd0,   OP_DUMP_DOWN, 32'h0000_0000, 1'b1, KIND_ENTRY, 32'haaaa_aaaa},
    '{1'b0, 7'd0,   OP_DUMP_UP,   32'h0000_0000, 1'b1, KIND_ENTRY, 32'haaaa_aaaa}
  };

  bounded_stack_with_dump_top #(
    .DEPTH(DEPTH_DEF)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_push_value(in_push_value),
    .out_strobe(out_strobe),
    .out_kind(out_kind),
    .out_entry(out_entry),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void apply_stack_op(op_t op, logic [DATA_W-1:0] value, bit emit);
    int unsigned eff_cap;
    int unsigned n;
    eff_cap = (model_cap > DEPTH_DEF) ? DEPTH_DEF : model_cap;
    n = model_fill;
    if (op == OP_PUSH) begin
      if (n >= eff_cap) begin
        if (emit) pending_results.push_back('{KIND_FULL, '0, 1'b1});
      end else begin
        model_mem[n] = value;
        model_fill = n + 1;
      end
    end else if (n == 0) begin
      if (emit) pending_results.push_back('{KIND_EMPTY, '0, 1'b1});
    end else if (op == OP_POP) begin
      model_fill = n - 1;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (emit) begin
          pending_results.push_back('{KIND_ENTRY,
                                     model_mem[(op == OP_DUMP_DOWN) ? (n - 1 - i) : i],
                                     (i == n - 1)});
        end
      end
    end
  endfunction

  function automatic void flag_mismatch(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      model_fill = 0;
      model_cap = CAP_RESET;
    end else begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transaction, expected none, %s %0d entry %h last %b",
                   $time, "actual kind", out_kind, out_entry, out_last);
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind)
            flag_mismatch("kind", DATA_W'(want.kind), DATA_W'(out_kind));
          if (out_entry !== want.entry) flag_mismatch("entry", want.entry, out_entry);
          if (out_last !== want.last)
            flag_mismatch("last", DATA_W'(want.last), DATA_W'(out_last));
        end
      end
      if (cfg_we) model_cap = cfg_wdata;
      if (start && !busy) begin
        apply_stack_op(op_t'(in_opcode), in_push_value, !expect_typed);
        if (expect_typed) pending_results.push_back('{typed_kind, typed_entry, 1'b1});
      end
    end
  end

  task automatic send_op(op_t op, logic [DATA_W-1:0] value, bit typed, kind_t x_kind,
                         logic [DATA_W-1:0] x_entry);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_opcode <= op;
    in_push_value <= value;
    expect_typed = typed;
    typed_kind = x_kind;
    typed_entry = x_entry;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_and_settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_push_value();
    unique case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    op_t op;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 26;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].is_cfg)
        write_capacity(directed_rows[r].cap);
      else
        send_op(directed_rows[r].op, directed_rows[r].value, directed_rows[r].typed,
                directed_rows[r].x_kind, directed_rows[r].x_entry);
    end

    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      sender_idle_pct = (s < 2) ? 26 : (s < 4) ? 65 : 0;
      write_capacity(CAP_W'(seg_cap[s]));
      for (int k = 0; k < seg_items[s]; k++) begin
        if ($urandom_range(99) < seg_dump_pct[s])
          op = $urandom_range(1) ? OP_DUMP_DOWN : OP_DUMP_UP;
        else if ($urandom_range(99) < seg_push_pct[s])
          op = OP_PUSH;
        else
          op = OP_POP;
        send_op(op, pick_push_value(), 1'b0, KIND_ENTRY, '0);
      end
    end

    drain_and_settle();
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[bounded_stack_with_dump_top.f]
hdl/bsd_pkg.sv
hdl/bsd_front.sv
hdl/bsd_queue.sv
hdl/bsd_back.sv
hdl/bounded_stack_with_dump_top.sv
bench/tb_bounded_stack_with_dump_top.sv
